[rtl/core/pics_pkg.sv]
// Shared constants, widths and types for the PI controller with integral separation.
package pics_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_LIMIT  = 3'd4;

    // Request opcodes
    localparam logic OP_CALC  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Field and datapath widths
    localparam int DATA_W   = 16;
    localparam int ERR_W    = 17;   // setpoint - measured, no wrap
    localparam int INTEG_W  = 21;   // accumulator, held in +/-1e6
    localparam int PPROD_W  = 33;   // error * prop_gain
    localparam int IPROD_W  = 37;   // integral * integ_gain
    localparam int PMAG_W   = 29;   // |error*kp| >> 3
    localparam int IMAG_W   = 30;   // |integral*ki| >> 5
    localparam int PQ_W     = 23;   // |error*kp| / 1000
    localparam int IQ_W     = 19;   // |integral*ki| / 100000
    localparam int ACC_W    = 26;   // drive_min + both terms

    // Integral bounds, one bit wider than the accumulator for the pre-clamp sum
    localparam logic signed [INTEG_W:0] INTEG_HI = 22'sd1000000;
    localparam logic signed [INTEG_W:0] INTEG_LO = -22'sd1000000;

    // x/1000 = ((x>>3) * ceil(2^36/125)) >> 36, exact for x>>3 below 2^29
    localparam int PMUL_W = PMAG_W + 30;
    localparam logic [29:0] PRECIP = 30'd549755814;
    localparam int PPRE_SH  = 3;
    localparam int PPOST_SH = 36;

    // x/100000 = ((x>>5) * ceil(2^42/3125)) >> 42, exact for x>>5 below 2^30
    localparam int IMUL_W = IMAG_W + 31;
    localparam logic [30:0] IRECIP = 31'd1407374884;
    localparam int IPRE_SH  = 5;
    localparam int IPOST_SH = 42;

    // Load enables for the two stages of the constant divider
    typedef struct packed {
        logic abs_en;
        logic mul_en;
    } div_en_t;

endpackage

[rtl/core/pics_divc.sv]
// Two-stage truncating division of both controller products by their fixed scales.
module pics_divc (
    input  logic                                 aclk,
    input  pics_pkg::div_en_t                    en,
    input  logic signed [pics_pkg::PPROD_W-1:0]  prop_prod,
    input  logic signed [pics_pkg::IPROD_W-1:0]  integ_prod,
    output logic signed [pics_pkg::PQ_W:0]       prop_quot,
    output logic signed [pics_pkg::IQ_W:0]       integ_quot
);

    logic [pics_pkg::PPROD_W-1:0] pabs;
    logic [pics_pkg::IPROD_W-1:0] iabs;
    logic [pics_pkg::PMAG_W-1:0]  pmag_reg;
    logic [pics_pkg::IMAG_W-1:0]  imag_reg;
    logic                         pneg_reg;
    logic                         ineg_reg;
    logic [pics_pkg::PMUL_W-1:0]  pmul;
    logic [pics_pkg::IMUL_W-1:0]  imul;
    logic [pics_pkg::PQ_W-1:0]    pq_reg;
    logic [pics_pkg::IQ_W-1:0]    iq_reg;
    logic                         pqneg_reg;
    logic                         iqneg_reg;

    // Magnitudes; division truncates toward zero, so work unsigned
    assign pabs = prop_prod[pics_pkg::PPROD_W-1]  ? -prop_prod  : prop_prod;
    assign iabs = integ_prod[pics_pkg::IPROD_W-1] ? -integ_prod : integ_prod;

    // Stage A: magnitude, pre-shift by the power-of-two factor of each scale
    always_ff @(posedge aclk) begin
        if (en.abs_en) begin
            pmag_reg <= pabs[pics_pkg::PPRE_SH +: pics_pkg::PMAG_W];
            imag_reg <= iabs[pics_pkg::IPRE_SH +: pics_pkg::IMAG_W];
            pneg_reg <= prop_prod[pics_pkg::PPROD_W-1];
            ineg_reg <= integ_prod[pics_pkg::IPROD_W-1];
        end
    end

    // Reciprocal multiplies for the odd factors
    assign pmul = pics_pkg::PMUL_W'(pmag_reg) * pics_pkg::PMUL_W'(pics_pkg::PRECIP);
    assign imul = pics_pkg::IMUL_W'(imag_reg) * pics_pkg::IMUL_W'(pics_pkg::IRECIP);

    // Stage B: keep only the quotient bits
    always_ff @(posedge aclk) begin
        if (en.mul_en) begin
            pq_reg    <= pmul[pics_pkg::PPOST_SH +: pics_pkg::PQ_W];
            iq_reg    <= imul[pics_pkg::IPOST_SH +: pics_pkg::IQ_W];
            pqneg_reg <= pneg_reg;
            iqneg_reg <= ineg_reg;
        end
    end

    // Restore signs
    assign prop_quot  = pqneg_reg ? -$signed({1'b0, pq_reg}) : $signed({1'b0, pq_reg});
    assign integ_quot = iqneg_reg ? -$signed({1'b0, iq_reg}) : $signed({1'b0, iq_reg});

endmodule

[rtl/core/pi_controller_integral_separation_top.sv]
// Positional PI controller with integral separation: channels, integrator and output pipeline.
//
// Usage:
//   Requests enter on the s_ stream. s_tuser[0] is the opcode (calculate or clear),
//   s_tdata carries setpoint in [15:0] and measured in [31:16]. A calculate request
//   gives one result on the m_ stream: m_tdata[15:0] is the clamped drive value and
//   m_tuser[0] is set when the error was added to the integral. A clear request
//   zeroes the integral and gives no result.
//   Gains, clamps and the separation limit are written on the cfg_ channel, which is
//   always ready; write it only while no request is in flight.
// Timing:
//   From acceptance to m_tvalid a request passes the input register, integrator, gain
//   multipliers, two stages of constant division, then the output register.
//   One request per cycle sustained while m_tready stays high; the integral
//   accumulate-and-clamp is the only feedback and is combinational into integ_reg.
// Reset and stall:
//   aresetn (synchronous, low) empties the pipeline, zeroes the integral and loads the
//   register reset values. When m_tready is low, requests keep entering until every
//   pipeline stage holds an item; then s_tready drops.
module pi_controller_integral_separation_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] setpoint, [31:16] measured
    input  logic [0:0]  s_tuser,    // [0] opcode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] drive
    output logic [0:0]  m_tuser,    // [0] integrating
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pics_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    logic signed [pics_pkg::DATA_W-1:0] kp_reg;
    logic signed [pics_pkg::DATA_W-1:0] ki_reg;
    logic signed [pics_pkg::DATA_W-1:0] dmax_reg;
    logic signed [pics_pkg::DATA_W-1:0] dmin_reg;
    logic signed [pics_pkg::DATA_W-1:0] sep_reg;

    // Pipeline registers
    logic                                v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic                                op0_reg;
    logic signed [pics_pkg::DATA_W-1:0]  sp0_reg, ms0_reg;
    logic signed [pics_pkg::ERR_W-1:0]   err1_reg;
    logic signed [pics_pkg::INTEG_W-1:0] ig1_reg;
    logic                                fl1_reg, fl2_reg, fl3_reg, fl4_reg;
    logic signed [pics_pkg::PPROD_W-1:0] pp2_reg;
    logic signed [pics_pkg::IPROD_W-1:0] ip2_reg;
    logic [pics_pkg::DATA_W-1:0]         drive_reg;
    logic                                flag_reg;

    // Integrator state
    logic signed [pics_pkg::INTEG_W-1:0] integ_reg, integ_next;

    // Stage readiness
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    // Combinational datapath
    logic signed [pics_pkg::ERR_W-1:0]   err_c;
    logic [pics_pkg::ERR_W-1:0]          mag_c;
    logic                                sep_hit;
    logic signed [pics_pkg::INTEG_W:0]   sum_c;
    logic signed [pics_pkg::INTEG_W-1:0] sat_c;
    logic signed [pics_pkg::PPROD_W-1:0] pp_c;
    logic signed [pics_pkg::IPROD_W-1:0] ip_c;
    logic signed [pics_pkg::PQ_W:0]      pquot;
    logic signed [pics_pkg::IQ_W:0]      iquot;
    logic signed [pics_pkg::ACC_W-1:0]   acc_c, hi_c, lo_c, capped_c;
    logic [pics_pkg::DATA_W-1:0]         drive_c;
    pics_pkg::div_en_t                   div_en;

    // Configuration write decode
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            dmax_reg <= 16'sh7FFF;
            dmin_reg <= '0;
            sep_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pics_pkg::REG_PROP_GAIN:  kp_reg   <= cfg_data;
                pics_pkg::REG_INTEG_GAIN: ki_reg   <= cfg_data;
                pics_pkg::REG_DRIVE_MAX:  dmax_reg <= cfg_data;
                pics_pkg::REG_DRIVE_MIN:  dmin_reg <= cfg_data;
                pics_pkg::REG_SEP_LIMIT:  sep_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Backpressure: a stage takes new data when empty or when it moves on
    assign rdy5     = !m_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;

    // Valid bits; clear requests drop out after the integrator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg      <= s_tvalid;
            if (rdy1) v1_reg      <= v0_reg && (op0_reg == pics_pkg::OP_CALC);
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) v4_reg      <= v3_reg;
            if (rdy5) m_valid_reg <= v4_reg;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (rdy0) begin
            op0_reg <= s_tuser[0];
            sp0_reg <= s_tdata[15:0];
            ms0_reg <= s_tdata[31:16];
        end
    end

    // Error, separation test and saturating accumulate
    assign err_c   = {sp0_reg[15], sp0_reg} - {ms0_reg[15], ms0_reg};
    assign mag_c   = err_c[pics_pkg::ERR_W-1] ? -err_c : err_c;
    assign sep_hit = $signed({1'b0, mag_c}) < $signed({{2{sep_reg[15]}}, sep_reg});
    assign sum_c   = {integ_reg[pics_pkg::INTEG_W-1], integ_reg}
                   + {{(pics_pkg::INTEG_W + 1 - pics_pkg::ERR_W){err_c[pics_pkg::ERR_W-1]}},
                      err_c};

    always_comb begin
        if (sum_c > pics_pkg::INTEG_HI) begin
            sat_c = pics_pkg::INTEG_HI[pics_pkg::INTEG_W-1:0];
        end else if (sum_c < pics_pkg::INTEG_LO) begin
            sat_c = pics_pkg::INTEG_LO[pics_pkg::INTEG_W-1:0];
        end else begin
            sat_c = sum_c[pics_pkg::INTEG_W-1:0];
        end
    end

    always_comb begin
        integ_next = integ_reg;
        if (v0_reg && rdy1) begin
            if (op0_reg == pics_pkg::OP_CLEAR) begin
                integ_next = '0;
            end else if (sep_hit) begin
                integ_next = sat_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else begin
            integ_reg <= integ_next;
        end
    end

    // Integrator stage register: error and updated integral travel together
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            err1_reg <= err_c;
            ig1_reg  <= integ_next;
            fl1_reg  <= sep_hit;
        end
    end

    // Gain multipliers
    assign pp_c = pics_pkg::PPROD_W'(err1_reg) * pics_pkg::PPROD_W'(kp_reg);
    assign ip_c = pics_pkg::IPROD_W'(ig1_reg) * pics_pkg::IPROD_W'(ki_reg);

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            pp2_reg <= pp_c;
            ip2_reg <= ip_c;
            fl2_reg <= fl1_reg;
        end
    end

    // Scale division, two stages
    assign div_en.abs_en = rdy3;
    assign div_en.mul_en = rdy4;

    pics_divc u_divc (
        .aclk       (aclk),
        .en         (div_en),
        .prop_prod  (pp2_reg),
        .integ_prod (ip2_reg),
        .prop_quot  (pquot),
        .integ_quot (iquot)
    );

    always_ff @(posedge aclk) begin
        if (rdy3) fl3_reg <= fl2_reg;
        if (rdy4) fl4_reg <= fl3_reg;
    end

    // Sum with base offset, clamp to max first and then to min
    assign lo_c  = pics_pkg::ACC_W'(dmin_reg);
    assign hi_c  = pics_pkg::ACC_W'(dmax_reg);
    assign acc_c = lo_c + pics_pkg::ACC_W'(pquot) + pics_pkg::ACC_W'(iquot);

    always_comb begin
        capped_c = (acc_c > hi_c) ? hi_c : acc_c;
        drive_c  = (capped_c < lo_c) ? dmin_reg : capped_c[pics_pkg::DATA_W-1:0];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (rdy5) begin
            drive_reg <= drive_c;
            flag_reg  <= fl4_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = flag_reg;

    // Integral never leaves its bounds
    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed({integ_reg[pics_pkg::INTEG_W-1], integ_reg}) <= pics_pkg::INTEG_HI) &&
        ($signed({integ_reg[pics_pkg::INTEG_W-1], integ_reg}) >= pics_pkg::INTEG_LO))
        else $error("integral out of range");

    // A clear request empties the integral
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && rdy1 && (op0_reg == pics_pkg::OP_CLEAR)) |=> (integ_reg == '0))
        else $error("integral not cleared");

    // Outside the separation band the integral holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && rdy1 && (op0_reg == pics_pkg::OP_CALC) && !sep_hit) |=> $stable(integ_reg))
        else $error("integral changed outside separation band");

endmodule
